FILE: sv/assert_macros.svh
// Assertion helpers shared by the transform unit RTL.
// Standalone header; pulled in by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a cause is followed by its effect.
`define ASSERT_IMPLIES(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> effect) \
      else $error("assertion failed");

`endif

FILE: sv/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform unit.
// No dependencies; imported by every module of the block.
package mvt_pkg;

   localparam int DIM        = 4;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int NUM_COMP   = 4;
   localparam int SUM_W      = PROD_W + $clog2(NUM_COMP);
   localparam int IDX_W      = 2;
   localparam int PIPE_STAGES = 3;
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_XFORM = 1'b1
   } func_type;

   // 1.0 and 0.0 in fixed point
   localparam word_type ONE_FIXED  = word_type'(64'd1 << FRAC_BITS);
   localparam word_type ZERO_FIXED = '0;

   localparam logic signed [SUM_W-1:0] SAT_MAX =
      {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_MIN =
      {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   localparam word_type WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      word_type w;
      logic     overflow;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             full;
   } fifo_status_type;

endpackage

FILE: sv/mvt_lane.sv
// One row lane: four products, pairwise add, final add, shift and saturate.
// Depends on mvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvt_lane (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mvt_pkg::word_type [mvt_pkg::NUM_COMP-1:0]   coef,
   input  mvt_pkg::word_type [mvt_pkg::NUM_COMP-1:0]   vec,
   output mvt_pkg::word_type                           result,
   output logic                                        sat
);
   import mvt_pkg::*;

   logic signed [PROD_W-1:0] prod_in [NUM_COMP];
   logic signed [PROD_W-1:0] prod_ff [NUM_COMP];
   logic signed [SUM_W-1:0]  pair_in [2];
   logic signed [SUM_W-1:0]  pair_ff [2];
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  shifted;
   word_type                 result_in;
   word_type                 result_ff;
   logic                     sat_in;
   logic                     sat_ff;

   always_comb begin
      for (int k = 0; k < NUM_COMP; k++) begin
         prod_in[k] = $signed(coef[k]) * $signed(vec[k]);
      end
      pair_in[0] = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]);
      pair_in[1] = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);
   end

   // Floor shift of the exact sum, then clamp to the word range.
   always_comb begin
      sum     = pair_ff[0] + pair_ff[1];
      shifted = sum >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
         result_in = WORD_MAX;
         sat_in    = 1'b1;
      end else if (shifted < SAT_MIN) begin
         result_in = WORD_MIN;
         sat_in    = 1'b1;
      end else begin
         result_in = shifted[DATA_W-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   assign result = result_ff;
   assign sat    = sat_ff;

   `ASSERT_IMPLIES(a_sat_is_extreme, clock, reset, sat_ff,
      (result_ff == WORD_MAX || result_ff == WORD_MIN))

endmodule

FILE: sv/mvt_merge.sv
// Merges lane results into one beat and buffers it for the result channel.
// Depends on mvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvt_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        wr_valid,
   input  mvt_pkg::word_type [mvt_pkg::NUM_COMP-1:0]   lane_result,
   input  logic [mvt_pkg::NUM_COMP-1:0]                lane_sat,
   output logic                                        rd_valid,
   input  logic                                        rd_ready,
   output mvt_pkg::result_type                         rd_data,
   output mvt_pkg::fifo_status_type                    status
);
   import mvt_pkg::*;

   result_type       mem_ff [FIFO_DEPTH];
   result_type       entry;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rd_fire;

   always_comb begin
      entry.x        = lane_result[0];
      entry.y        = lane_result[1];
      entry.z        = lane_result[2];
      entry.w        = lane_result[3];
      entry.overflow = |lane_sat;
   end

   assign rd_valid = (count_ff != '0);
   assign rd_fire  = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_valid ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_fire  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(wr_valid) - CNT_W'(rd_fire);
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign status.count = count_ff;
   assign status.full  = (count_ff == CNT_W'(FIFO_DEPTH));

   `ASSERT_ALWAYS(a_no_write_when_full, clock, reset, !(wr_valid && status.full))
   `ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_W'(FIFO_DEPTH))

endmodule

FILE: sv/matrix_vector_transform_4x4_unit.sv
// Homogeneous 4x4 matrix-vector transform: one lane per matrix row.
// Depends on mvt_pkg, mvt_lane, mvt_merge and assert_macros.svh.
//
// Takes one beat per cycle while req_ready is high. A load beat (func 0) writes
// one Q16.16 matrix entry at row/col and returns nothing; the matrix resets to
// identity. A transform beat (func 1) returns the matrix times (x, y, z, w), each
// sum floored to Q16.16 and saturated, with overflow set if any component clamped.
// A transform result passes three lane stages (multiply, pairwise add, final add
// with shift and saturate) and is then written into an eight-entry result buffer
// that drives rsp_valid. req_ready stays high until eight transform results are
// outstanding, so one beat per cycle is sustained whenever rsp_ready is held high.
`include "assert_macros.svh"

module matrix_vector_transform_4x4_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [mvt_pkg::IDX_W-1:0]     req_row,
   input  logic [mvt_pkg::IDX_W-1:0]     req_col,
   input  mvt_pkg::word_type             req_entry_value,
   input  mvt_pkg::word_type             req_x_in,
   input  mvt_pkg::word_type             req_y_in,
   input  mvt_pkg::word_type             req_z_in,
   input  mvt_pkg::word_type             req_w_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mvt_pkg::word_type             rsp_x_out,
   output mvt_pkg::word_type             rsp_y_out,
   output mvt_pkg::word_type             rsp_z_out,
   output mvt_pkg::word_type             rsp_w_out,
   output logic                          rsp_overflow
);
   import mvt_pkg::*;

   word_type                       matrix_ff [DIM][DIM];
   word_type [NUM_COMP-1:0]        vec;
   word_type [NUM_COMP-1:0]        lane_result;
   logic [NUM_COMP-1:0]            lane_sat;
   logic [PIPE_STAGES-1:0]         pipe_v_ff;
   logic [PIPE_STAGES-1:0]         pipe_v_in;
   logic [CNT_W-1:0]               outstanding_ff;
   logic [CNT_W-1:0]               outstanding_in;
   logic                           req_fire;
   logic                           load_fire;
   logic                           xform_fire;
   logic                           rsp_fire;
   result_type                     rd_data;
   fifo_status_type                fifo_status;

   assign req_ready  = (outstanding_ff < CNT_W'(FIFO_DEPTH));
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_func == FUNC_LOAD);
   assign xform_fire = req_fire && (req_func == FUNC_XFORM);
   assign rsp_fire   = rsp_valid && rsp_ready;

   always_comb begin
      vec[0] = req_x_in;
      vec[1] = req_y_in;
      vec[2] = req_z_in;
      vec[3] = req_w_in;
   end

   // Matrix store; writes outside the matrix fall through untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               matrix_ff[i][j] <= (i == j) ? ONE_FIXED : ZERO_FIXED;
            end
         end
      end else begin
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               if (load_fire && req_row == IDX_W'(i) && req_col == IDX_W'(j)) begin
                  matrix_ff[i][j] <= req_entry_value;
               end
            end
         end
      end
   end

   for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
      if (i < DIM) begin : g_active
         word_type [NUM_COMP-1:0] coef;
         word_type [NUM_COMP-1:0] lane_vec;

         always_comb begin
            for (int j = 0; j < NUM_COMP; j++) begin
               coef[j]     = (j < DIM) ? matrix_ff[i][j] : ZERO_FIXED;
               lane_vec[j] = (j < DIM) ? vec[j] : ZERO_FIXED;
            end
         end

         mvt_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .coef   (coef),
            .vec    (lane_vec),
            .result (lane_result[i]),
            .sat    (lane_sat[i])
         );
      end else begin : g_unused
         assign lane_result[i] = ZERO_FIXED;
         assign lane_sat[i]    = 1'b0;
      end
   end

   always_comb begin
      pipe_v_in      = {pipe_v_ff[PIPE_STAGES-2:0], xform_fire};
      outstanding_in = outstanding_ff + CNT_W'(xform_fire) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff      <= '0;
         outstanding_ff <= '0;
      end else begin
         pipe_v_ff      <= pipe_v_in;
         outstanding_ff <= outstanding_in;
      end
   end

   mvt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .wr_valid    (pipe_v_ff[PIPE_STAGES-1]),
      .lane_result (lane_result),
      .lane_sat    (lane_sat),
      .rd_valid    (rsp_valid),
      .rd_ready    (rsp_ready),
      .rd_data     (rd_data),
      .status      (fifo_status)
   );

   assign rsp_x_out    = rd_data.x;
   assign rsp_y_out    = rd_data.y;
   assign rsp_z_out    = rd_data.z;
   assign rsp_w_out    = rd_data.w;
   assign rsp_overflow = rd_data.overflow;

   `ASSERT_ALWAYS(a_outstanding_matches, clock, reset,
      outstanding_ff == CNT_W'($countones(pipe_v_ff)) + fifo_status.count)
   `ASSERT_IMPLIES(a_xform_reaches_buffer, clock, reset, xform_fire,
      ##3 pipe_v_ff[PIPE_STAGES-1])
   `ASSERT_IMPLIES(a_load_no_result, clock, reset, load_fire, ##1 !pipe_v_ff[0])

endmodule
